### rtl/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

    // register reset values
    localparam logic [14:0] AXIS_LENGTH_RESET = 15'd1802;
    localparam logic [14:0] MAX_SPEED_RESET   = 15'd4096;
    localparam logic [15:0] TIME_STEP_RESET   = 16'd655;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_AXIS_LENGTH = 2'd0,
        REG_MAX_SPEED   = 2'd1,
        REG_TIME_STEP   = 2'd2
    } cfg_reg_t;

    // divider geometry: quotients stay below 2^DIV_QUOT_W
    localparam int DIV_NUM_W  = 36;
    localparam int DIV_DEN_W  = 19;
    localparam int DIV_QUOT_W = 20;

    typedef logic signed [19:0] angle_t;

    localparam angle_t PI_Q13      = 20'sd25736;
    localparam angle_t TWO_PI_Q13  = 20'sd51472;
    localparam angle_t PI_Q14      = 20'sd51472;
    localparam angle_t TWO_PI_Q14  = 20'sd102944;
    localparam angle_t PI_Q16      = 20'sd205887;
    localparam angle_t HALF_PI_Q16 = 20'sd102944;

    localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032875;
    localparam int CORDIC_STEPS = 17;

    function automatic angle_t atan_q16(input logic [4:0] idx);
        angle_t r;
        case (idx)
            5'd0:    r = 20'sd51472;
            5'd1:    r = 20'sd30386;
            5'd2:    r = 20'sd16055;
            5'd3:    r = 20'sd8150;
            5'd4:    r = 20'sd4091;
            5'd5:    r = 20'sd2047;
            5'd6:    r = 20'sd1024;
            5'd7:    r = 20'sd512;
            5'd8:    r = 20'sd256;
            5'd9:    r = 20'sd128;
            5'd10:   r = 20'sd64;
            5'd11:   r = 20'sd32;
            5'd12:   r = 20'sd16;
            5'd13:   r = 20'sd8;
            5'd14:   r = 20'sd4;
            5'd15:   r = 20'sd2;
            5'd16:   r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

    // truncating remainder, then fold into [-pi, pi]; input stays below three turns
    function automatic angle_t wrap_angle(input angle_t a, input angle_t two_pi,
                                          input angle_t pi);
        angle_t r;
        r = a;
        if (r >= two_pi)
        begin
            r = r - two_pi;
        end
        if (r >= two_pi)
        begin
            r = r - two_pi;
        end
        if (r <= -two_pi)
        begin
            r = r + two_pi;
        end
        if (r <= -two_pi)
        begin
            r = r + two_pi;
        end
        if (r > pi)
        begin
            r = r - two_pi;
        end
        if (r < -pi)
        begin
            r = r + two_pi;
        end
        return r;
    endfunction

endpackage

### rtl/diff_drive_odometry_step_top.sv
`timescale 1ns / 1ps
// when the wheels are limited, two extra scaling steps run, each a multiply and a 20-step division
// (one for each wheel); the shared multiplier, the 20-step divider and the 17-step cordic loop
// are used in turn for each word
// one word is in work at a time; a finished word waits in the output register
// reset clears pose and heading to zero and loads the register defaults

module diff_drive_odometry_step_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] command_speed,
    input  logic signed [15:0] command_turn_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [15:0] pose_heading,
    output logic signed [15:0] left_wheel_speed,
    output logic signed [15:0] right_wheel_speed,
    output logic               speed_limited,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [22:0] {
        ST_IDLE     = 23'd1 << 0,
        ST_HALF_MUL = 23'd1 << 1,
        ST_WHEELS   = 23'd1 << 2,
        ST_LIMIT    = 23'd1 << 3,
        ST_SMUL     = 23'd1 << 4,
        ST_SDIV0    = 23'd1 << 5,
        ST_SDIV     = 23'd1 << 6,
        ST_DMUL     = 23'd1 << 7,
        ST_DDIV0    = 23'd1 << 8,
        ST_DDIV     = 23'd1 << 9,
        ST_MID      = 23'd1 << 10,
        ST_CINIT    = 23'd1 << 11,
        ST_CORDIC   = 23'd1 << 12,
        ST_CFIX     = 23'd1 << 13,
        ST_PMUL     = 23'd1 << 14,
        ST_PSAVE    = 23'd1 << 15,
        ST_HI       = 23'd1 << 16,
        ST_LO       = 23'd1 << 17,
        ST_ACC      = 23'd1 << 18,
        ST_RND      = 23'd1 << 19,
        ST_POS      = 23'd1 << 20,
        ST_HEAD     = 23'd1 << 21,
        ST_DONE     = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] axis_reg, max_reg;
    logic [15:0] dt_reg;
    logic [14:0] axis_eff;

    logic signed [31:0] x_reg, y_reg;
    logic signed [15:0] h_reg;
    logic signed [15:0] u_reg, w_reg;
    logic signed [19:0] left_reg, right_reg;
    logic [18:0]        m_reg;
    logic               limited_reg;
    logic               side_reg;
    logic               coord_reg;
    logic               neg_reg;
    logic signed [19:0] dbeta_reg;
    logic signed [32:0] cx_reg, cy_reg;
    ddo_pkg::angle_t    cz_reg;
    logic               flip_reg;
    logic [4:0]         cnt_reg;
    logic signed [33:0] p_reg;
    logic signed [65:0] acc_reg;
    logic signed [53:0] prod_reg;

    logic signed [31:0] ox_reg, oy_reg;
    logic signed [15:0] oh_reg, ol_reg, or_reg;
    logic               olim_reg, out_valid_reg;

    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;

    logic signed [31:0] half_sum;
    logic signed [19:0] half_w;
    logic signed [19:0] abs_l, abs_r;
    logic signed [20:0] wheel_diff, wheel_sum;
    logic signed [53:0] prod_abs;
    logic signed [19:0] wheel_sel;
    logic signed [32:0] coord_c;

    logic                             div_start;
    logic [ddo_pkg::DIV_NUM_W-1:0]    div_num;
    logic [ddo_pkg::DIV_DEN_W-1:0]    div_den;
    logic                             div_done;
    logic [ddo_pkg::DIV_QUOT_W-1:0]   div_quo;
    logic signed [19:0]               quo_s;

    logic signed [32:0] xs, ys;
    ddo_pkg::angle_t    atan_v;
    ddo_pkg::angle_t    mid_a;
    ddo_pkg::angle_t    head_a;
    logic signed [22:0] delta;
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;

    assign axis_eff  = (axis_reg == 15'd0) ? 15'd1 : axis_reg;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    // w*axis/2 in Q4.12, half away from zero
    assign half_sum = $signed(prod_reg[31:0]) + 32'sd4096 - {31'd0, prod_reg[31]};
    assign half_w   = 20'($signed(half_sum[31:13]));

    assign abs_l      = left_reg[19] ? -left_reg : left_reg;
    assign abs_r      = right_reg[19] ? -right_reg : right_reg;
    assign wheel_diff = 21'(right_reg) - 21'(left_reg);
    assign wheel_sum  = 21'(right_reg) + 21'(left_reg);
    assign prod_abs   = prod_reg[53] ? -prod_reg : prod_reg;
    assign wheel_sel  = side_reg ? right_reg : left_reg;
    assign coord_c    = coord_reg ? cy_reg : cx_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HALF_MUL:
            begin
                mul_a = 36'(w_reg);
                mul_b = 18'(axis_eff);
            end
            ST_SMUL:
            begin
                mul_a = 36'(wheel_sel);
                mul_b = 18'(max_reg);
            end
            ST_DMUL:
            begin
                mul_a = 36'(wheel_diff);
                mul_b = 18'(dt_reg);
            end
            ST_PMUL:
            begin
                mul_a = 36'(wheel_sum);
                mul_b = 18'(dt_reg);
            end
            ST_HI:
            begin
                mul_a = 36'(p_reg);
                mul_b = 18'($signed(coord_c[32:16]));
            end
            ST_LO:
            begin
                mul_a = 36'(p_reg);
                mul_b = {2'b00, coord_c[15:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 54'(mul_a * mul_b);
    end

    // divider works on magnitudes, rounding bias added up front
    assign div_start = (state_reg == ST_SDIV0) || (state_reg == ST_DDIV0);
    always_comb
    begin
        if (state_reg == ST_DDIV0)
        begin
            div_num = prod_abs[35:0] + 36'({axis_eff, 2'b00});
            div_den = 19'({axis_eff, 3'b000});
        end
        else
        begin
            div_num = prod_abs[35:0] + 36'(m_reg >> 1);
            div_den = m_reg;
        end
    end

    ddo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign quo_s = neg_reg ? -$signed(20'(div_quo)) : $signed(20'(div_quo));

    assign xs     = cx_reg >>> cnt_reg;
    assign ys     = cy_reg >>> cnt_reg;
    assign atan_v = ddo_pkg::atan_q16(cnt_reg);
    assign mid_a  = ddo_pkg::wrap_angle(20'(h_reg) + 20'(h_reg) + dbeta_reg,
                                        ddo_pkg::TWO_PI_Q14, ddo_pkg::PI_Q14);
    assign head_a = ddo_pkg::wrap_angle(20'(h_reg) + dbeta_reg,
                                        ddo_pkg::TWO_PI_Q13, ddo_pkg::PI_Q13);

    assign delta   = $signed(acc_reg[65:43]);
    assign pos_sum = (coord_reg ? 34'(y_reg) : 34'(x_reg)) + 34'(delta);
    always_comb
    begin
        if (!pos_sum[33] && (pos_sum[32:31] != 2'b00))
        begin
            pos_sat = 32'h7fffffff;
        end
        else if (pos_sum[33] && (pos_sum[32:31] != 2'b11))
        begin
            pos_sat = 32'h80000000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     state_next = in_valid ? ST_HALF_MUL : ST_IDLE;
            ST_HALF_MUL: state_next = ST_WHEELS;
            ST_WHEELS:   state_next = ST_LIMIT;
            ST_LIMIT:
            begin
                state_next = ((abs_l > abs_r ? abs_l[18:0] : abs_r[18:0]) > 19'(max_reg))
                             ? ST_SMUL : ST_DMUL;
            end
            ST_SMUL:     state_next = ST_SDIV0;
            ST_SDIV0:    state_next = ST_SDIV;
            ST_SDIV:
            begin
                if (div_done)
                begin
                    state_next = side_reg ? ST_DMUL : ST_SMUL;
                end
            end
            ST_DMUL:     state_next = ST_DDIV0;
            ST_DDIV0:    state_next = ST_DDIV;
            ST_DDIV:     state_next = div_done ? ST_MID : ST_DDIV;
            ST_MID:      state_next = ST_CINIT;
            ST_CINIT:    state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                state_next = (cnt_reg == 5'(ddo_pkg::CORDIC_STEPS - 1)) ? ST_CFIX : ST_CORDIC;
            end
            ST_CFIX:     state_next = ST_PMUL;
            ST_PMUL:     state_next = ST_PSAVE;
            ST_PSAVE:    state_next = ST_HI;
            ST_HI:       state_next = ST_LO;
            ST_LO:       state_next = ST_ACC;
            ST_ACC:      state_next = ST_RND;
            ST_RND:      state_next = ST_POS;
            ST_POS:      state_next = coord_reg ? ST_HEAD : ST_HI;
            ST_HEAD:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= ddo_pkg::AXIS_LENGTH_RESET;
            max_reg       <= ddo_pkg::MAX_SPEED_RESET;
            dt_reg        <= ddo_pkg::TIME_STEP_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ddo_pkg::REG_AXIS_LENGTH: axis_reg <= cfg_data[14:0];
                    ddo_pkg::REG_MAX_SPEED:   max_reg  <= cfg_data[14:0];
                    ddo_pkg::REG_TIME_STEP:   dt_reg   <= cfg_data;
                    default:                  ;
                endcase
            end
            if ((state_reg == ST_POS) && !coord_reg)
            begin
                x_reg <= pos_sat;
            end
            if ((state_reg == ST_POS) && coord_reg)
            begin
                y_reg <= pos_sat;
            end
            if (state_reg == ST_HEAD)
            begin
                h_reg <= head_a[15:0];
            end
            if ((state_reg == ST_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                u_reg    <= command_speed;
                w_reg    <= command_turn_rate;
                side_reg <= 1'b0;
            end
            ST_WHEELS:
            begin
                left_reg  <= 20'(u_reg) - half_w;
                right_reg <= 20'(u_reg) + half_w;
            end
            ST_LIMIT:
            begin
                m_reg       <= (abs_l > abs_r) ? abs_l[18:0] : abs_r[18:0];
                limited_reg <= ((abs_l > abs_r ? abs_l[18:0] : abs_r[18:0]) > 19'(max_reg));
            end
            ST_SDIV0, ST_DDIV0:
            begin
                neg_reg <= prod_reg[53];
            end
            ST_SDIV:
            begin
                if (div_done)
                begin
                    if (side_reg)
                    begin
                        right_reg <= quo_s;
                    end
                    else
                    begin
                        left_reg <= quo_s;
                    end
                    side_reg <= 1'b1;
                end
            end
            ST_DDIV:
            begin
                if (div_done)
                begin
                    dbeta_reg <= quo_s;
                end
            end
            ST_MID:
            begin
                cz_reg <= mid_a <<< 2;
            end
            ST_CINIT:
            begin
                // fold into the right half plane, negate the result later
                if (cz_reg > ddo_pkg::HALF_PI_Q16)
                begin
                    cz_reg   <= cz_reg - ddo_pkg::PI_Q16;
                    flip_reg <= 1'b1;
                end
                else if (cz_reg < -ddo_pkg::HALF_PI_Q16)
                begin
                    cz_reg   <= cz_reg + ddo_pkg::PI_Q16;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    flip_reg <= 1'b0;
                end
                cx_reg  <= ddo_pkg::CORDIC_K_Q30;
                cy_reg  <= '0;
                cnt_reg <= '0;
            end
            ST_CORDIC:
            begin
                if (!cz_reg[19])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_CFIX:
            begin
                if (flip_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            ST_PSAVE:
            begin
                p_reg     <= prod_reg[33:0];
                coord_reg <= 1'b0;
            end
            ST_LO:
            begin
                acc_reg <= 66'(prod_reg) <<< 16;
            end
            ST_ACC:
            begin
                acc_reg <= acc_reg + 66'(prod_reg);
            end
            ST_RND:
            begin
                acc_reg <= acc_reg + (66'sd1 <<< 42) - {65'd0, acc_reg[65]};
            end
            ST_POS:
            begin
                coord_reg <= 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ox_reg   <= x_reg;
                    oy_reg   <= y_reg;
                    oh_reg   <= h_reg;
                    ol_reg   <= left_reg[15:0];
                    or_reg   <= right_reg[15:0];
                    olim_reg <= limited_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign pose_x            = ox_reg;
    assign pose_y            = oy_reg;
    assign pose_heading      = oh_reg;
    assign left_wheel_speed  = ol_reg;
    assign right_wheel_speed = or_reg;
    assign speed_limited     = olim_reg;

endmodule

### rtl/ddo_div.sv
`timescale 1ns / 1ps

module ddo_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ddo_pkg::DIV_NUM_W-1:0]     num,
    input  logic [ddo_pkg::DIV_DEN_W-1:0]     den,
    output logic                              done,
    output logic [ddo_pkg::DIV_QUOT_W-1:0]    quo
);

    localparam int NW = ddo_pkg::DIV_NUM_W;
    localparam int DW = ddo_pkg::DIV_DEN_W;
    localparam int QW = ddo_pkg::DIV_QUOT_W;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] sh_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW+1:0] trial;
    logic          qbit;

    // restoring step: one quotient bit a cycle
    assign trial = {1'b0, rem_reg, sh_reg[QW-1]} - {2'b00, den_reg};
    assign qbit  = ~trial[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num[NW-1:QW]);
            sh_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? trial[DW-1:0] : {rem_reg[DW-2:0], sh_reg[QW-1]};
            sh_reg  <= {sh_reg[QW-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule
